@@ hdl/simplex_noise_3d_eval_macros.svh @@
// Assertion macros for the simplex noise evaluator.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef SIMPLEX_NOISE_3D_EVAL_MACROS_SVH
`define SIMPLEX_NOISE_3D_EVAL_MACROS_SVH
`ifndef SYNTH
// Check a condition in the same cycle as its trigger.
`define SNZ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snz same-cycle check failed");
// Check a condition in the cycle after its trigger.
`define SNZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snz next-cycle check failed");
`else
`define SNZ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SNZ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/snz_pkg.sv @@
// Shared types, constants and functions for the simplex noise evaluator.
// No dependencies; compile first after the macro header.
package snz_pkg;

    localparam int SNZ_COORD_FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int NOISE_W   = 18;
    localparam int CW        = 30;  // corner offset, signed Q.28
    localparam int QW        = 29;  // scaled offset divided by three
    localparam int DOT_W     = 32;
    localparam int T_W       = 30;  // falloff terms, Q.30
    localparam int CONTRIB_W = 24;

    localparam logic [55:0] SIX_TENTHS_Q56 = 56'h99999999999999;

    typedef logic signed [CW-1:0] ofs_t;
    typedef logic [2:0] axis_t;
    typedef logic [5:0] hash_t;

    typedef struct packed {
        ofs_t       quot;
        logic [1:0] rem;
    } corr_t;

    localparam ofs_t ALPHA_BIAS = 30'sd134217728;

    function automatic logic [5:0] bit_table(input logic [2:0] idx);
        logic [5:0] v;
        case (idx)
            3'd0: v = 6'h15;
            3'd1: v = 6'h38;
            3'd2: v = 6'h32;
            3'd3: v = 6'h2c;
            3'd4: v = 6'h0d;
            3'd5: v = 6'h13;
            3'd6: v = 6'h07;
            default: v = 6'h2a;
        endcase
        return v;
    endfunction

    function automatic hash_t lattice_hash(input logic [7:0] i, input logic [7:0] j,
                                           input logic [7:0] k);
        logic [8:0] acc;
        acc = 9'(bit_table({i[0], j[0], k[0]})) + 9'(bit_table({j[1], k[1], i[1]}))
            + 9'(bit_table({k[2], i[2], j[2]})) + 9'(bit_table({i[3], j[3], k[3]}))
            + 9'(bit_table({j[4], k[4], i[4]})) + 9'(bit_table({k[5], i[5], j[5]}))
            + 9'(bit_table({i[6], j[6], k[6]})) + 9'(bit_table({j[7], k[7], i[7]}));
        return acc[5:0];
    endfunction

    // floor(m * 2^27 / 3) and its remainder, m = corner index - 6 * axis step
    function automatic corr_t axis_corr(input logic ax, input logic [1:0] na);
        corr_t r;
        case ({ax, na})
            3'b001:  r = '{quot: 30'sd44739242,   rem: 2'd2};
            3'b010:  r = '{quot: 30'sd89478485,   rem: 2'd1};
            3'b011:  r = '{quot: 30'sd134217728,  rem: 2'd0};
            3'b101:  r = '{quot: -30'sd223696214, rem: 2'd2};
            3'b110:  r = '{quot: -30'sd178956971, rem: 2'd1};
            3'b111:  r = '{quot: -30'sd134217728, rem: 2'd0};
            default: r = '{quot: 30'sd0,          rem: 2'd0};
        endcase
        return r;
    endfunction

    function automatic logic signed [DOT_W-1:0] grad_dot(input ofs_t c0, input ofs_t c1,
                                                         input ofs_t c2, input hash_t h);
        logic signed [DOT_W-1:0] p;
        logic signed [DOT_W-1:0] q;
        logic signed [DOT_W-1:0] r;
        logic signed [DOT_W-1:0] d;
        case (h[1:0])
            2'd1:
            begin
                p = DOT_W'(c0);
                q = DOT_W'(c1);
                r = DOT_W'(c2);
            end
            2'd2:
            begin
                p = DOT_W'(c1);
                q = DOT_W'(c2);
                r = DOT_W'(c0);
            end
            default:
            begin
                p = DOT_W'(c2);
                q = DOT_W'(c0);
                r = DOT_W'(c1);
            end
        endcase
        if (h[5] == h[3])
            p = -p;
        if (h[5] == h[4])
            q = -q;
        if (h[5] != (h[4] ^ h[3]))
            r = -r;
        if (h[1:0] == 2'd0)
            d = p + q + r;
        else if (!h[2])
            d = p + q;
        else
            d = p + r;
        return d;
    endfunction

endpackage

@@ hdl/snz_if.sv @@
// Point and noise channel interfaces for the simplex noise evaluator.
// Depends on snz_pkg for the field widths.
interface snz_point_if import snz_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface snz_noise_if import snz_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [NOISE_W-1:0]  noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

@@ hdl/simplex_noise_3d_eval.sv @@
// Top level of the 3D simplex noise evaluator: cell search, corner ranking,
// hashing and the final sum. Depends on snz_pkg, snz_if, snz_corner and the macro header.
//
// Usage:
//   point (sink): one transfer carries pos_x, pos_y, pos_z, signed fixed point
//   with COORD_FRAC_BITS fraction bits. noise (source): one transfer per point
//   carries noise_value, signed Q2.16, saturated at both ends.
//   Points come out in the order they went in, one result each.
//   Throughput is one point per cycle; the pipeline is 12 register stages
//   (five for cell search and ranking, six in each corner unit, one output).
//   All stages advance together: when noise holds a result that is not taken,
//   the whole pipeline holds and point.ready drops; nothing is lost or repeated.
//   Reset clears every stage valid bit; data registers are not reset.
//   The block keeps no state between points and has no configuration.
`include "simplex_noise_3d_eval_macros.svh"

module simplex_noise_3d_eval
    import snz_pkg::*;
#(
    parameter int COORD_FRAC_BITS = SNZ_COORD_FRAC_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    snz_point_if.sink     point,
    snz_noise_if.source   noise
);

    localparam int NSTAGE   = 12;
    localparam int OW       = COORD_FRAC_BITS + 4;   // offsets scaled by 6*2^F
    localparam int GW       = COORD_FRAC_BITS + 2;
    localparam int SCALE_SH = 27 - COORD_FRAC_BITS;

    localparam logic [34:0] SUM_BIAS   = 35'h3_0000_0000;  // 3 * 2^32
    localparam logic [17:0] RECIP3_18  = 18'd174763;
    localparam logic [18:0] RECIP3_20  = 19'd349526;
    localparam logic [30:0] X_BIAS     = 31'h1800_0000;    // 3 * 2^27
    localparam logic [31:0] RECIP3_32  = 32'h5555_5556;

    localparam axis_t AXIS_X    = 3'b001;
    localparam axis_t AXIS_Y    = 3'b010;
    localparam axis_t AXIS_Z    = 3'b100;
    localparam axis_t AXIS_NONE = 3'b000;
    localparam axis_t AXIS_ALL  = 3'b111;

    localparam logic signed [25:0] OUT_MAX = 26'sd131071;
    localparam logic signed [25:0] OUT_MIN = -26'sd131072;

    logic                       en;
    logic [NSTAGE-1:0]          v_reg;

    // stage 1: captured point
    logic signed [COORD_W-1:0]  pos_reg [3];

    // stage 2: high half of sum / 3
    logic [34:0]                sum_off;
    logic [35:0]                hi_prod;
    logic [16:0]                qh_next;
    logic [16:0]                qh_reg;
    logic [1:0]                 rh_reg;
    logic [16:0]                lo_reg;
    logic signed [COORD_W-1:0]  pos2_reg [3];

    // stage 3: floor(sum / 3), low word, and remainder
    logic [18:0]                y_div;
    logic [37:0]                lo_prod;
    logic [16:0]                ql;
    logic [31:0]                fs_reg;
    logic [1:0]                 r_reg;
    logic signed [COORD_W-1:0]  pos3_reg [3];

    // stage 4: unskewed offsets and cell low bytes
    logic [31:0]                tsum [3];
    logic [COORD_FRAC_BITS-1:0] gfrac [3];
    logic [GW-1:0]              gsum;
    logic signed [OW-1:0]       off_next [3];
    logic signed [OW-1:0]       off_reg [3];
    logic [7:0]                 cell_next [3];
    logic [7:0]                 cellb_reg [3];

    // stage 5: corner order, offset thirds, hashes
    axis_t                      hi_oh;
    axis_t                      lo_oh;
    logic [30:0]                xoff [3];
    logic [62:0]                mprod [3];
    logic [2:0][QW-1:0]         quot_next;
    logic [2:0][1:0]            xlo_next;
    logic [2:0][QW-1:0]         quot_reg;
    logic [2:0][1:0]            xlo_reg;
    axis_t [3:0]                axis_next;
    axis_t [3:0]                axis_reg;
    hash_t [3:0]                hash_next;
    hash_t [3:0]                hash_reg;

    // corner units and output
    logic signed [CONTRIB_W-1:0] contrib [4];
    logic signed [25:0]         acc;
    logic signed [NOISE_W-1:0]  noise_next;
    logic signed [NOISE_W-1:0]  noise_reg;

    // Advance every stage unless the output holds a result that is not taken
    assign en          = !v_reg[NSTAGE-1] || noise.ready;
    assign point.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NSTAGE-2:0], point.valid};
    end

    // Split floor(sum / 3) into two narrow reciprocal multiplies; bias keeps it unsigned
    always_comb
    begin
        sum_off = 35'(pos_reg[0]) + 35'(pos_reg[1]) + 35'(pos_reg[2]) + SUM_BIAS;
        hi_prod = 36'(sum_off[34:17]) * 36'(RECIP3_18);
        qh_next = hi_prod[35:19];
    end

    always_comb
    begin
        y_div   = {rh_reg, lo_reg};
        lo_prod = 38'(y_div) * 38'(RECIP3_20);
        ql      = lo_prod[36:20];
    end

    // Offsets reduce to 6*g - sum(g) + r, where g is the floor remainder per axis
    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            tsum[n]      = 32'(pos3_reg[n]) + fs_reg;
            gfrac[n]     = tsum[n][COORD_FRAC_BITS-1:0];
            cell_next[n] = tsum[n][COORD_FRAC_BITS+7:COORD_FRAC_BITS];
        end
        gsum = GW'(gfrac[0]) + GW'(gfrac[1]) + GW'(gfrac[2]);
        for (int n = 0; n < 3; n++)
            off_next[n] = $signed(OW'(gfrac[n]) * OW'(3'd6) - OW'(gsum) + OW'(r_reg));
    end

    // Rank the offsets: largest axis steps first, smallest last
    always_comb
    begin
        if (off_reg[0] >= off_reg[2])
            hi_oh = (off_reg[0] >= off_reg[1]) ? AXIS_X : AXIS_Y;
        else
            hi_oh = (off_reg[1] >= off_reg[2]) ? AXIS_Y : AXIS_Z;
        if (off_reg[0] < off_reg[2])
            lo_oh = (off_reg[0] < off_reg[1]) ? AXIS_X : AXIS_Y;
        else
            lo_oh = (off_reg[1] < off_reg[2]) ? AXIS_Y : AXIS_Z;

        axis_next[0] = AXIS_NONE;
        axis_next[1] = hi_oh;
        axis_next[2] = ~lo_oh;
        axis_next[3] = AXIS_ALL;

        for (int n = 0; n < 3; n++)
        begin
            xoff[n]      = 31'(31'(off_reg[n]) <<< SCALE_SH) + X_BIAS;
            mprod[n]     = 63'(xoff[n]) * 63'(RECIP3_32);
            quot_next[n] = mprod[n][60:32];
            xlo_next[n]  = xoff[n][1:0];
        end

        for (int k = 0; k < 4; k++)
            hash_next[k] = lattice_hash(cellb_reg[0] + 8'(axis_next[k][0]),
                                        cellb_reg[1] + 8'(axis_next[k][1]),
                                        cellb_reg[2] + 8'(axis_next[k][2]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[0] <= point.pos_x;
            pos_reg[1] <= point.pos_y;
            pos_reg[2] <= point.pos_z;

            qh_reg    <= qh_next;
            rh_reg    <= sum_off[18:17] + qh_next[1:0];
            lo_reg    <= sum_off[16:0];
            pos2_reg  <= pos_reg;

            fs_reg    <= 32'({qh_reg, 17'd0}) + 32'(ql);
            r_reg     <= y_div[1:0] + ql[1:0];
            pos3_reg  <= pos2_reg;

            off_reg   <= off_next;
            cellb_reg <= cell_next;

            quot_reg  <= quot_next;
            xlo_reg   <= xlo_next;
            axis_reg  <= axis_next;
            hash_reg  <= hash_next;

            noise_reg <= noise_next;
        end
    end

    for (genvar gi = 0; gi < 4; gi++)
    begin : g_corner
        snz_corner u_corner
        (
            .clk     (clk),
            .en      (en),
            .quot    (quot_reg),
            .xlo     (xlo_reg),
            .axis    (axis_reg[gi]),
            .hash    (hash_reg[gi]),
            .contrib (contrib[gi])
        );
    end

    // Sum the four corners and clamp to Q2.16
    always_comb
    begin
        acc = 26'(contrib[0]) + 26'(contrib[1]) + 26'(contrib[2]) + 26'(contrib[3]);
        if (acc > OUT_MAX)
            noise_next = NOISE_W'(OUT_MAX);
        else if (acc < OUT_MIN)
            noise_next = NOISE_W'(OUT_MIN);
        else
            noise_next = acc[NOISE_W-1:0];
    end

    assign noise.valid       = v_reg[NSTAGE-1];
    assign noise.noise_value = noise_reg;

    `SNZ_ASSERT_NOW(a_rem_hi, clk, rst_n, v_reg[1], rh_reg != 2'd3)
    `SNZ_ASSERT_NOW(a_rem_lo, clk, rst_n, v_reg[2], r_reg != 2'd3)
    `SNZ_ASSERT_NOW(a_axis_order, clk, rst_n, v_reg[4], $countones(axis_reg[1]) == 1 && $countones(axis_reg[2]) == 2 && (axis_reg[1] & ~axis_reg[2]) == AXIS_NONE)
    `SNZ_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, $stable(v_reg))

endmodule

@@ hdl/snz_corner.sv @@
// Six-stage pipeline for one simplex corner: offsets, squared distance,
// gradient dot, falloff powers and contribution. Depends on snz_pkg.
module snz_corner
    import snz_pkg::*;
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [2:0][QW-1:0]           quot,
    input  logic [2:0][1:0]              xlo,
    input  axis_t                        axis,
    input  hash_t                        hash,
    output logic signed [CONTRIB_W-1:0]  contrib
);

    logic [1:0]               na;
    corr_t                    corr [3];
    logic [1:0]               beta [3];
    logic [2:0]               bsum [3];
    ofs_t                     c_next [3];
    ofs_t                     c_reg [3];
    hash_t                    h_reg;

    logic signed [59:0]       sq_next [3];
    logic signed [59:0]       sq_reg [3];
    logic signed [DOT_W-1:0]  dot_next;
    logic signed [DOT_W-1:0]  dot2_reg;

    logic signed [60:0]       d2;
    logic signed [60:0]       t56;
    logic [T_W-1:0]           t30_next;
    logic [T_W-1:0]           t30_reg;
    logic signed [DOT_W-1:0]  dot3_reg;

    logic [2*T_W-1:0]         t2_prod;
    logic [T_W-1:0]           t2_reg;
    logic signed [DOT_W-1:0]  dot4_reg;

    logic [2*T_W-1:0]         t4_prod;
    logic [T_W-1:0]           t4_reg;
    logic signed [DOT_W-1:0]  dot5_reg;

    logic signed [62:0]       c_prod;
    logic signed [CONTRIB_W-1:0] contrib_reg;

    // Rebuild each Q.28 offset from the shared third and a per-axis correction
    always_comb
    begin
        na = 2'(axis[0]) + 2'(axis[1]) + 2'(axis[2]);
        for (int i = 0; i < 3; i++)
        begin
            corr[i]   = axis_corr(axis[i], na);
            beta[i]   = xlo[i] + quot[i][1:0];
            bsum[i]   = 3'(beta[i]) + 3'(corr[i].rem);
            c_next[i] = ofs_t'(quot[i]) - ALPHA_BIAS + corr[i].quot
                      + ofs_t'(bsum[i] >= 3'd3);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = c_reg[i] * c_reg[i];
        dot_next = grad_dot(c_reg[0], c_reg[1], c_reg[2], h_reg);
    end

    // Drop the corner when the falloff goes negative
    always_comb
    begin
        d2       = 61'(sq_reg[0]) + 61'(sq_reg[1]) + 61'(sq_reg[2]);
        t56      = $signed({5'd0, SIX_TENTHS_Q56}) - d2;
        t30_next = t56[60] ? '0 : t56[55:26];
    end

    assign t2_prod = 60'(t30_reg) * 60'(t30_reg);
    assign t4_prod = 60'(t2_reg) * 60'(t2_reg);
    assign c_prod  = $signed({1'b0, t4_reg}) * dot5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg       <= c_next;
            h_reg       <= hash;
            sq_reg      <= sq_next;
            dot2_reg    <= dot_next;
            t30_reg     <= t30_next;
            dot3_reg    <= dot2_reg;
            t2_reg      <= t2_prod[59:30];
            dot4_reg    <= dot3_reg;
            t4_reg      <= t4_prod[59:30];
            dot5_reg    <= dot4_reg;
            contrib_reg <= c_prod[62:39];
        end
    end

    assign contrib = contrib_reg;

endmodule
